// File: design/psa_pkg.sv
`default_nettype none

package psa_pkg;

   // Operation codes carried in the request word.
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   // Status codes returned in the response word.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
   localparam logic [1:0] STATUS_NOT_USED  = 2'd2;

   // The bitmap is stored as memory words of this many slot bits.
   localparam int WORD_BITS  = 32;
   localparam int WORD_SHIFT = 5;

   typedef struct packed {
      logic       func;
      logic [9:0] slot_index;
   } psa_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [9:0]  granted_slot;
      logic        all_free;
      logic [10:0] used_count;
   } psa_rsp_type;

endpackage

`default_nettype wire

// File: design/pool_slot_allocator.sv
`default_nettype none

// Bitmap allocator for a pool of POOL_SLOTS buffer slots.
// The request channel (req_) carries one word per operation: allocate the
// lowest free slot at or above the search hint, or free the slot named in
// slot_index. Every request gives exactly one word on the response channel
// (rsp_) with a status, the granted slot, the in-use count and an all-free
// flag. The in-use bits live in a single-port-write memory of 32-bit words
// with a registered read.
// Sequence: a free passes through S_FREE, which updates the word read from
// the bitmap, and S_POST; an allocate scans one bitmap word at a time in
// S_SCAN from the hint, up to ceil(POOL_SLOTS/32) words (32 at the default
// size), so the word-at-a-time scan loop sets the allocate rate. An allocate
// that starts with the pool already exhausted, or a free of a slot beyond the
// pool, goes straight to S_POST. One request is worked on at a time.
// Reset starts a clearing pass that writes ceil(POOL_SLOTS/32) memory words
// to zero, one a cycle; req_stall is high during the pass.
// The response sits in an output register, so a request may be accepted
// while the previous response is stalled; a finished result then waits
// until the response register is free.
module pool_slot_allocator
   import psa_pkg::*;
#(
   parameter int POOL_SLOTS = 1024
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  wire psa_req_type req_word,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output psa_rsp_type      rsp_word
);

   localparam int WORDS = (POOL_SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int CW    = $clog2(WORDS + 1);
   localparam int HW    = $clog2(POOL_SLOTS + 1);
   localparam int REM   = POOL_SLOTS % WORD_BITS;
   localparam logic [WORD_BITS-1:0] LAST_MASK =
      (REM == 0) ? {WORD_BITS{1'b1}} : WORD_BITS'((64'd1 << REM) - 64'd1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_FREE,
      S_POST
   } state_type;

   state_type             state_ff, state_in;
   logic [CW-1:0]         eval_word_ff, eval_word_in;
   logic [WORD_SHIFT-1:0] slot_bit_ff, slot_bit_in;
   logic                  first_ff, first_in;
   logic [HW-1:0]         hint_ff, hint_in;
   logic [HW-1:0]         count_ff, count_in;
   logic [1:0]            pend_status_ff, pend_status_in;
   logic [9:0]            pend_slot_ff, pend_slot_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   psa_rsp_type           rsp_ff, rsp_in;

   // Bitmap memory and its ports.
   logic [WORD_BITS-1:0]  bitmap_mem [WORDS];
   logic [WORD_BITS-1:0]  rd_data_ff;
   logic [AW-1:0]         rd_addr;
   logic                  mem_we;
   logic [AW-1:0]         mem_wa;
   logic [WORD_BITS-1:0]  mem_wd;

   // Scan evaluation signals.
   logic [WORD_BITS-1:0]  lo_mask;
   logic [WORD_BITS-1:0]  valid_mask;
   logic [WORD_BITS-1:0]  scan_free;
   logic                  scan_found;
   logic [WORD_SHIFT-1:0] scan_pos;
   logic [HW-1:0]         scan_slot;
   logic [HW-1:0]         free_slot;
   logic                  accept;
   logic                  rsp_open;

   // Lowest set bit of a word; the caller checks that some bit is set.
   function automatic logic [WORD_SHIFT-1:0] lowest_set(input logic [WORD_BITS-1:0] bits);
      logic [WORD_SHIFT-1:0] pos;
      pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (bits[i]) begin
            pos = WORD_SHIFT'(i);
         end
      end
      return pos;
   endfunction

   assign accept   = req_valid && (state_ff == S_IDLE);
   assign rsp_open = !rsp_valid_ff || !rsp_stall;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // Free bits of the word under scan, ignoring slots below the hint in the
   // first word and slots past the end of the pool in the last one.
   always_comb begin
      lo_mask    = first_ff ? ({WORD_BITS{1'b1}} << WORD_SHIFT'(hint_ff))
                            : {WORD_BITS{1'b1}};
      valid_mask = (eval_word_ff == CW'(WORDS - 1)) ? LAST_MASK : {WORD_BITS{1'b1}};
      scan_free  = ~rd_data_ff & lo_mask & valid_mask;
      scan_found = |scan_free;
      scan_pos   = lowest_set(scan_free);
      scan_slot  = HW'({eval_word_ff, scan_pos});
      free_slot  = HW'({eval_word_ff, slot_bit_ff});
   end

   // Next-state logic of the sequencer.
   always_comb begin
      state_in       = state_ff;
      eval_word_in   = eval_word_ff;
      slot_bit_in    = slot_bit_ff;
      first_in       = first_ff;
      hint_in        = hint_ff;
      count_in       = count_ff;
      pend_status_in = pend_status_ff;
      pend_slot_in   = pend_slot_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_in         = rsp_ff;
      rd_addr        = AW'(eval_word_ff + CW'(1));
      mem_we         = 1'b0;
      mem_wa         = AW'(eval_word_ff);
      mem_wd         = rd_data_ff;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wd = '0;
            if (eval_word_ff == CW'(WORDS - 1)) begin
               eval_word_in = '0;
               state_in     = S_IDLE;
            end else begin
               eval_word_in = eval_word_ff + CW'(1);
            end
         end

         S_IDLE: begin
            if (accept) begin
               pend_slot_in = '0;
               if (req_word.func == FUNC_FREE) begin
                  if (32'(req_word.slot_index) < POOL_SLOTS) begin
                     eval_word_in = CW'(req_word.slot_index >> WORD_SHIFT);
                     slot_bit_in  = req_word.slot_index[WORD_SHIFT-1:0];
                     rd_addr      = AW'(req_word.slot_index >> WORD_SHIFT);
                     state_in     = S_FREE;
                  end else begin
                     pend_status_in = STATUS_NOT_USED;
                     state_in       = S_POST;
                  end
               end else begin
                  if (hint_ff == HW'(POOL_SLOTS)) begin
                     pend_status_in = STATUS_EXHAUSTED;
                     state_in       = S_POST;
                  end else begin
                     eval_word_in = CW'(hint_ff >> WORD_SHIFT);
                     rd_addr      = AW'(hint_ff >> WORD_SHIFT);
                     first_in     = 1'b1;
                     state_in     = S_SCAN;
                  end
               end
            end
         end

         S_SCAN: begin
            first_in = 1'b0;
            if (scan_found) begin
               mem_we         = 1'b1;
               mem_wd         = rd_data_ff | (WORD_BITS'(1) << scan_pos);
               count_in       = count_ff + HW'(1);
               hint_in        = scan_slot + HW'(1);
               pend_status_in = STATUS_OK;
               pend_slot_in   = 10'(scan_slot);
               state_in       = S_POST;
            end else if (eval_word_ff == CW'(WORDS - 1)) begin
               hint_in        = HW'(POOL_SLOTS);
               pend_status_in = STATUS_EXHAUSTED;
               state_in       = S_POST;
            end else begin
               eval_word_in = eval_word_ff + CW'(1);
            end
         end

         S_FREE: begin
            if (rd_data_ff[slot_bit_ff]) begin
               mem_we         = 1'b1;
               mem_wd         = rd_data_ff & ~(WORD_BITS'(1) << slot_bit_ff);
               count_in       = count_ff - HW'(1);
               pend_status_in = STATUS_OK;
               if (free_slot < hint_ff) begin
                  hint_in = free_slot;
               end
            end else begin
               pend_status_in = STATUS_NOT_USED;
            end
            state_in = S_POST;
         end

         S_POST: begin
            // The result waits here until the response register is free.
            if (rsp_open) begin
               rsp_in.status       = pend_status_ff;
               rsp_in.granted_slot = pend_slot_ff;
               rsp_in.all_free     = (count_ff == '0);
               rsp_in.used_count   = 11'(count_ff);
               rsp_valid_in        = 1'b1;
               state_in            = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Sequencer state and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         eval_word_ff <= '0;
         first_ff     <= 1'b0;
         hint_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         eval_word_ff <= eval_word_in;
         first_ff     <= first_in;
         hint_ff      <= hint_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      slot_bit_ff    <= slot_bit_in;
      pend_status_ff <= pend_status_in;
      pend_slot_ff   <= pend_slot_in;
      rsp_ff         <= rsp_in;
   end

   // Bitmap memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bitmap_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= bitmap_mem[rd_addr];
   end

endmodule

`default_nettype wire

// File: tb/sv/pool_slot_allocator_tb.sv
`timescale 1ns / 100ps

module pool_slot_allocator_tb;
   import psa_pkg::*;

   localparam int POOL_SIZE    = 1024;
   localparam int IDLE_LIMIT   = 3000;
   localparam int TAIL_CYCLES  = 40;
   localparam int CHURN_ITEMS  = 80;
   localparam int DRAIN_ITEMS  = 100;
   localparam int N_DIRECTED   = 21;
   localparam logic CHECK_TYPED = 1'b1;
   localparam logic CHECK_MODEL = 1'b0;

   typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_type;

   // One row of the directed table: the request word and, where it is
   // obvious, the response word typed in by hand.
   typedef struct packed {
      logic        typed;
      psa_req_type req;
      psa_rsp_type rsp;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   psa_req_type req_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   psa_rsp_type rsp_word;

   // Mirror of the allocator state.
   logic [POOL_SIZE-1:0] slot_used = '0;
   logic [10:0]          scan_hint = '0;
   logic [10:0]          used_total = '0;

   psa_rsp_type      awaited_words[$];
   directed_row_type directed_rows[N_DIRECTED];

   int             mismatch_count = 0;
   int             idle_cycles = 0;
   int             burst_left = 0;
   int             alloc_sent = 0;
   int             free_sent = 0;
   int             exhausted_seen = 0;
   int             not_used_seen = 0;
   int             peak_used = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left = 0;

   pool_slot_allocator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Apply one request to the mirrored bitmap and return the response word.
   function automatic psa_rsp_type apply_slot_op(input psa_req_type w);
      psa_rsp_type r;
      r = '0;
      r.status = STATUS_OK;
      if (w.func == FUNC_ALLOC) begin
         while (scan_hint < POOL_SIZE && slot_used[scan_hint[9:0]])
            scan_hint = scan_hint + 11'd1;
         if (scan_hint < POOL_SIZE) begin
            slot_used[scan_hint[9:0]] = 1'b1;
            used_total = used_total + 11'd1;
            r.granted_slot = scan_hint[9:0];
            scan_hint = scan_hint + 11'd1;
         end else begin
            r.status = STATUS_EXHAUSTED;
         end
      end else if (slot_used[w.slot_index]) begin
         slot_used[w.slot_index] = 1'b0;
         used_total = used_total - 11'd1;
         if ({1'b0, w.slot_index} < scan_hint)
            scan_hint = {1'b0, w.slot_index};
      end else begin
         r.status = STATUS_NOT_USED;
      end
      r.all_free = (used_total == 11'd0);
      r.used_count = used_total;
      return r;
   endfunction

   // Random request word. Most frees name a slot that is in use, so that
   // they get past the already-free check.
   function automatic psa_req_type random_word(input int alloc_pct);
      psa_req_type w;
      int unsigned roll;
      int unsigned start;
      w.slot_index = 10'($urandom_range(0, POOL_SIZE - 1));
      roll = $urandom_range(0, 99);
      start = $urandom_range(0, POOL_SIZE - 1);
      if ($urandom_range(0, 99) < alloc_pct) begin
         w.func = FUNC_ALLOC;
      end else begin
         w.func = FUNC_FREE;
         if (roll < 70 && used_total != 11'd0) begin
            for (int k = 0; k < POOL_SIZE; k++) begin
               if (slot_used[(start + k) % POOL_SIZE]) begin
                  w.slot_index = 10'((start + k) % POOL_SIZE);
                  break;
               end
            end
         end else if (roll < 80) begin
            w.slot_index = roll[0] ? 10'd1023 : 10'd0;
         end
      end
      return w;
   endfunction

   // Send one word in bursts with random gaps, then record what the block
   // must answer once it is accepted.
   task automatic issue(input psa_req_type w, input logic typed, input psa_rsp_type typed_rsp);
      int gap;
      psa_rsp_type predicted;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = apply_slot_op(w);
      awaited_words.push_back(typed ? typed_rsp : predicted);
      if (w.func == FUNC_ALLOC) alloc_sent++;
      else free_sent++;
      if (int'(used_total) > peak_used) peak_used = int'(used_total);
   endtask

   // Hold the sender off until every outstanding word has come back.
   task automatic wait_all_answered();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (awaited_words.size() != 0);
   endtask

   // Stimulus.
   initial begin
      // Directed rows: response typed in where it is obvious.
      directed_rows[0]  = {CHECK_TYPED, FUNC_FREE,  10'd0,
                           STATUS_NOT_USED, 10'd0, 1'b1, 11'd0};
      directed_rows[1]  = {CHECK_TYPED, FUNC_FREE,  10'd1023,
                           STATUS_NOT_USED, 10'd0, 1'b1, 11'd0};
      directed_rows[2]  = {CHECK_TYPED, FUNC_ALLOC, 10'd1023,
                           STATUS_OK, 10'd0, 1'b0, 11'd1};
      directed_rows[3]  = {CHECK_TYPED, FUNC_ALLOC, 10'd0,
                           STATUS_OK, 10'd1, 1'b0, 11'd2};
      directed_rows[4]  = {CHECK_TYPED, FUNC_ALLOC, 10'h2AA,
                           STATUS_OK, 10'd2, 1'b0, 11'd3};
      directed_rows[5]  = {CHECK_TYPED, FUNC_FREE,  10'd1,
                           STATUS_OK, 10'd0, 1'b0, 11'd2};
      directed_rows[6]  = {CHECK_TYPED, FUNC_FREE,  10'd1,
                           STATUS_NOT_USED, 10'd0, 1'b0, 11'd2};
      // The hint was lowered by the free, so slot 1 comes back first.
      directed_rows[7]  = {CHECK_MODEL, FUNC_ALLOC, 10'h155, 24'd0};
      directed_rows[8]  = {CHECK_MODEL, FUNC_ALLOC, 10'd0, 24'd0};
      directed_rows[9]  = {CHECK_MODEL, FUNC_FREE,  10'd0, 24'd0};
      directed_rows[10] = {CHECK_MODEL, FUNC_FREE,  10'd2, 24'd0};
      directed_rows[11] = {CHECK_MODEL, FUNC_ALLOC, 10'd0, 24'd0};
      // This scan steps over slot 1, which is still in use.
      directed_rows[12] = {CHECK_MODEL, FUNC_ALLOC, 10'd0, 24'd0};
      directed_rows[13] = {CHECK_MODEL, FUNC_FREE,  10'h2AA, 24'd0};
      directed_rows[14] = {CHECK_MODEL, FUNC_FREE,  10'd3, 24'd0};
      directed_rows[15] = {CHECK_MODEL, FUNC_FREE,  10'd1, 24'd0};
      directed_rows[16] = {CHECK_MODEL, FUNC_FREE,  10'd0, 24'd0};
      directed_rows[17] = {CHECK_TYPED, FUNC_FREE,  10'd2,
                           STATUS_OK, 10'd0, 1'b1, 11'd0};
      directed_rows[18] = {CHECK_TYPED, FUNC_FREE,  10'd512,
                           STATUS_NOT_USED, 10'd0, 1'b1, 11'd0};
      directed_rows[19] = {CHECK_TYPED, FUNC_ALLOC, 10'd1023,
                           STATUS_OK, 10'd0, 1'b0, 11'd1};
      directed_rows[20] = {CHECK_TYPED, FUNC_FREE,  10'd0,
                           STATUS_OK, 10'd0, 1'b1, 11'd0};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         issue(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);

      // Churn at a low fill level.
      repeat (CHURN_ITEMS) issue(random_word(60), CHECK_MODEL, '0);
      wait_all_answered();

      // Fill the pool, mostly by allocation.
      while (used_total != POOL_SIZE) issue(random_word(97), CHECK_MODEL, '0);

      // Pool exhausted: the hint sits at the top until a free lowers it, and
      // a free far from the lowest hole forces a long scan.
      repeat (3) issue({FUNC_ALLOC, 10'h3FF}, CHECK_MODEL, '0);
      issue({FUNC_FREE, 10'd1023}, CHECK_MODEL, '0);
      issue({FUNC_ALLOC, 10'd0}, CHECK_MODEL, '0);
      issue({FUNC_ALLOC, 10'd0}, CHECK_MODEL, '0);
      issue({FUNC_FREE, 10'd0}, CHECK_MODEL, '0);
      issue({FUNC_FREE, 10'd700}, CHECK_MODEL, '0);
      issue({FUNC_ALLOC, 10'd0}, CHECK_MODEL, '0);
      issue({FUNC_ALLOC, 10'd0}, CHECK_MODEL, '0);
      issue({FUNC_ALLOC, 10'd0}, CHECK_MODEL, '0);

      // Partial drain of a nearly full pool.
      repeat (DRAIN_ITEMS) issue(random_word(30), CHECK_MODEL, '0);

      wait_all_answered();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d allocates and %0d frees; %0d answered pool exhausted,",
               alloc_sent, free_sent, exhausted_seen);
      $display("%0d answered slot already free; peak of %0d slots in use.",
               not_used_seen, peak_used);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Receiver stall pattern: stretches of no stall, light and heavy stall.
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 2));
         mode_left <= $urandom_range(8, 60);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         STALL_LIGHT: begin
            rsp_stall <= ($urandom_range(0, 99) < 30);
         end
         STALL_HEAVY: begin
            rsp_stall <= ($urandom_range(0, 99) < 75);
         end
         default: begin
            rsp_stall <= 1'b0;
         end
      endcase
   end

   // Compare each accepted response word with the oldest awaited word.
   always @(posedge clock) begin
      psa_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (awaited_words.size() == 0) begin
            $display("%0t: response word with none awaited: %h", $time, rsp_word);
            mismatch_count++;
         end else begin
            want = awaited_words.pop_front();
            if (want.status == STATUS_EXHAUSTED) exhausted_seen++;
            if (want.status == STATUS_NOT_USED) not_used_seen++;
            if (rsp_word.status !== want.status) begin
               $display("%0t: status expected %0d, got %0d",
                        $time, want.status, rsp_word.status);
               mismatch_count++;
            end
            if (rsp_word.granted_slot !== want.granted_slot) begin
               $display("%0t: granted_slot expected %0d, got %0d",
                        $time, want.granted_slot, rsp_word.granted_slot);
               mismatch_count++;
            end
            if (rsp_word.all_free !== want.all_free) begin
               $display("%0t: all_free expected %0d, got %0d",
                        $time, want.all_free, rsp_word.all_free);
               mismatch_count++;
            end
            if (rsp_word.used_count !== want.used_count) begin
               $display("%0t: used_count expected %0d, got %0d",
                        $time, want.used_count, rsp_word.used_count);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: too long without a word accepted on either side.
   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no word accepted for %0d cycles", $time, IDLE_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
